// File: hw/rtl/bautp_pkg.sv
// ============================================================================
// BLE advertising UUID/ticket parser package
// Shared constants and payload types for the parser core and its submodules.
// ============================================================================
package bautp_pkg;

    // Default sizes of the ticket store and of the advertising payload.
    localparam int TICKET_MAX_DEF = 32;
    localparam int ADV_MAX_DEF    = 31;

    // Width of a stored ticket length; covers the largest supported TICKET_MAX (64).
    localparam int TKT_LEN_W = 7;

    // AD structure types of interest.
    localparam logic [7:0] AD_TYPE_UUID128_PART  = 8'h06;
    localparam logic [7:0] AD_TYPE_UUID128_FULL  = 8'h07;
    localparam logic [7:0] AD_TYPE_MANUFACTURER  = 8'hFF;

    // A 128-bit UUID carries this many data bytes.
    localparam int UUID_DATA_BYTES = 16;

    // Configuration register indexes.
    localparam logic CFG_UUID_LO = 1'b0;
    localparam logic CFG_UUID_HI = 1'b1;

    // Result kinds.
    localparam logic KIND_TICKET  = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [7:0] adv_byte;
        logic [4:0] frame_len;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] ticket_char;
        logic [5:0] ticket_count;
        logic       match_found;
        logic       run_end;
    } t_out_item;

    // Summary of one parsed frame, handed from the parser to the drain side.
    typedef struct packed {
        logic                 match;
        logic [TKT_LEN_W-1:0] len;
    } t_frame_desc;

endpackage

// File: hw/rtl/bautp_front.sv
// ============================================================================
// Parser front end
// Walks the length-type-data structures of a frame one byte per transfer,
// writes ticket bytes into the ticket store and emits a frame summary.
// ============================================================================
module bautp_front #(
    parameter int TICKET_MAX = bautp_pkg::TICKET_MAX_DEF,
    parameter int ADV_MAX    = bautp_pkg::ADV_MAX_DEF,
    parameter int AW         = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  bautp_pkg::t_in_item    i_item,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_wbank,
    output logic                   o_wr_en,
    output logic [AW:0]            o_wr_addr,
    output logic [7:0]             o_wr_data,
    output logic                   o_desc_push,
    output bautp_pkg::t_frame_desc o_desc
);
    import bautp_pkg::*;

    localparam int BLW = $clog2(ADV_MAX + 1);
    localparam int LW  = $clog2(TICKET_MAX + 1);

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    logic [63:0]    r_uuid_lo, r_uuid_hi;
    logic           r_in_frame, n_in_frame;
    logic [BLW-1:0] r_bl, n_bl;
    logic [1:0]     r_ph, n_ph;
    logic [7:0]     r_slen, n_slen;
    logic [7:0]     r_type, n_type;
    logic [4:0]     r_dp, n_dp;
    logic           r_eq, n_eq;
    logic           r_useen, n_useen;
    logic           r_tseen, n_tseen;
    logic [LW-1:0]  r_tlen, n_tlen;

    logic [8:0]     clamp_len;
    logic [BLW-1:0] cur_bl;
    logic [1:0]     cur_ph;
    logic           cur_useen, cur_tseen;
    logic [LW-1:0]  cur_tlen;
    logic [7:0]     b;
    logic [127:0]   uuid_all;
    logic [7:0]     uuid_b;
    logic           uuid_type;
    logic [4:0]     idx;
    logic [4:0]     dp1;
    logic           close_now;

    always_comb begin
        b         = i_item.adv_byte;
        uuid_all  = {r_uuid_hi, r_uuid_lo};
        uuid_b    = uuid_all[{r_dp[3:0], 3'b000} +: 8];
        uuid_type = (r_type == AD_TYPE_UUID128_PART) || (r_type == AD_TYPE_UUID128_FULL);
        idx       = r_dp - 5'd2;
        dp1       = r_dp + 5'd1;
        close_now = 1'b0;

        clamp_len = ({4'b0, i_item.frame_len} > 9'(ADV_MAX)) ? 9'(ADV_MAX)
                                                             : {4'b0, i_item.frame_len};
        // The first byte of a frame starts from a clean parse state.
        cur_bl    = r_in_frame ? r_bl : BLW'(clamp_len);
        cur_ph    = r_in_frame ? r_ph : PH_LEN;
        cur_useen = r_in_frame & r_useen;
        cur_tseen = r_in_frame & r_tseen;
        cur_tlen  = r_in_frame ? r_tlen : '0;

        n_in_frame = r_in_frame;
        n_bl       = r_bl;
        n_ph       = r_ph;
        n_slen     = r_slen;
        n_type     = r_type;
        n_dp       = r_dp;
        n_eq       = r_eq;
        n_useen    = r_useen;
        n_tseen    = r_tseen;
        n_tlen     = r_tlen;
        o_wr_en    = 1'b0;
        o_wr_addr  = {i_wbank, AW'(idx)};
        o_wr_data  = b;

        if (i_accept) begin
            n_in_frame = 1'b1;
            n_bl       = cur_bl;
            n_ph       = cur_ph;
            n_useen    = cur_useen;
            n_tseen    = cur_tseen;
            n_tlen     = cur_tlen;
            if ((cur_bl != '0) && (cur_ph != PH_STOP)) begin
                n_bl = cur_bl - BLW'(1);
                case (cur_ph)
                    PH_LEN: begin
                        if ((b == 8'd0) || (9'(n_bl) < {1'b0, b})) begin
                            n_ph = PH_STOP;
                        end else begin
                            n_slen = b;
                            n_ph   = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type = b;
                        n_dp   = 5'd0;
                        n_eq   = 1'b1;
                        if (b == AD_TYPE_MANUFACTURER) begin
                            n_tseen = 1'b1;
                            n_tlen  = '0;
                        end
                        // A type-only structure cannot hold a full UUID.
                        n_ph = (r_slen == 8'd1) ? PH_LEN : PH_DATA;
                    end
                    PH_DATA: begin
                        if (uuid_type && (r_dp < 5'(UUID_DATA_BYTES)) && (b != uuid_b)) begin
                            n_eq = 1'b0;
                        end
                        // Ticket bytes follow the two-byte company ID.
                        if ((r_type == AD_TYPE_MANUFACTURER) && (r_dp >= 5'd2)
                            && (32'(idx) < TICKET_MAX)) begin
                            o_wr_en = 1'b1;
                            n_tlen  = LW'(32'(idx) + 1);
                        end
                        n_dp      = dp1;
                        close_now = (({4'b0, dp1} + 9'd1) == {1'b0, r_slen});
                        if (close_now) begin
                            if (uuid_type && (r_slen == 8'(UUID_DATA_BYTES + 1)) && n_eq) begin
                                n_useen = 1'b1;
                            end
                            n_ph = PH_LEN;
                        end
                    end
                    default: begin
                        n_ph = PH_STOP;
                    end
                endcase
            end
            if (i_item.frame_end) begin
                n_in_frame = 1'b0;
                n_bl       = '0;
                n_ph       = PH_LEN;
            end
        end

        o_desc_push = i_accept & i_item.frame_end;
        o_desc.match = n_useen & n_tseen;
        o_desc.len   = TKT_LEN_W'(n_tlen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid_lo  <= '0;
            r_uuid_hi  <= '0;
            r_in_frame <= 1'b0;
            r_bl       <= '0;
            r_ph       <= PH_LEN;
            r_slen     <= '0;
            r_type     <= '0;
            r_dp       <= '0;
            r_eq       <= 1'b0;
            r_useen    <= 1'b0;
            r_tseen    <= 1'b0;
            r_tlen     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_UUID_LO) begin
                    r_uuid_lo <= i_cfg_data;
                end else begin
                    r_uuid_hi <= i_cfg_data;
                end
            end
            r_in_frame <= n_in_frame;
            r_bl       <= n_bl;
            r_ph       <= n_ph;
            r_slen     <= n_slen;
            r_type     <= n_type;
            r_dp       <= n_dp;
            r_eq       <= n_eq;
            r_useen    <= n_useen;
            r_tseen    <= n_tseen;
            r_tlen     <= n_tlen;
        end
    end

endmodule

// File: hw/rtl/bautp_frameq.sv
// ============================================================================
// Frame summary queue
// Two slots, one per ticket store bank, between the parser and the drain side.
// ============================================================================
module bautp_frameq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  bautp_pkg::t_frame_desc i_desc,
    input  logic                   i_pop,
    output logic                   o_full,
    output logic                   o_wbank,
    output logic                   o_head_valid,
    output logic                   o_rbank,
    output bautp_pkg::t_frame_desc o_head
);
    import bautp_pkg::*;

    logic [1:0]  r_slot_v;
    t_frame_desc r_slot [2];
    logic        r_wbank, r_rbank;

    // The parser owns bank r_wbank; it must wait while that bank still drains.
    assign o_full       = r_slot_v[r_wbank];
    assign o_wbank      = r_wbank;
    assign o_head_valid = r_slot_v[r_rbank];
    assign o_rbank      = r_rbank;
    assign o_head       = r_slot[r_rbank];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wbank] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_v <= '0;
            r_wbank  <= 1'b0;
            r_rbank  <= 1'b0;
        end else begin
            if (i_push) begin
                r_slot_v[r_wbank] <= 1'b1;
                r_wbank           <= ~r_wbank;
            end
            if (i_pop) begin
                r_slot_v[r_rbank] <= 1'b0;
                r_rbank           <= ~r_rbank;
            end
        end
    end

endmodule

// File: hw/rtl/bautp_back.sv
// ============================================================================
// Result drain
// Holds the two-bank ticket store and streams each frame's ticket bytes and
// verdict through a read stage and an output register.
// ============================================================================
module bautp_back #(
    parameter int TICKET_MAX = bautp_pkg::TICKET_MAX_DEF,
    parameter int AW         = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [AW:0]            i_wr_addr,
    input  logic [7:0]             i_wr_data,
    input  logic                   i_head_valid,
    input  logic                   i_rbank,
    input  bautp_pkg::t_frame_desc i_head,
    output logic                   o_desc_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output bautp_pkg::t_out_item   o_item
);
    import bautp_pkg::*;

    localparam int LW = $clog2(TICKET_MAX + 1);

    logic [7:0]    r_mem [2 * (2 ** AW)];
    logic [LW-1:0] r_idx;
    logic          r_a_v, r_a_kind, r_a_match;
    logic [5:0]    r_a_cnt;
    logic [7:0]    r_rd_data;
    logic          r_b_v;
    t_out_item     r_b;

    logic b_adv, a_move, issue, is_ticket;

    always_comb begin
        b_adv      = !r_b_v || i_pop;
        a_move     = r_a_v && b_adv;
        issue      = i_head_valid && (!r_a_v || a_move);
        is_ticket  = TKT_LEN_W'(r_idx) < i_head.len;
        o_desc_pop = issue && !is_ticket;
    end

    assign o_empty = !r_b_v;
    assign o_item  = r_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{i_rbank, AW'(r_idx)}];
            r_a_kind  <= is_ticket ? KIND_TICKET : KIND_VERDICT;
            r_a_cnt   <= 6'(i_head.len);
            r_a_match <= i_head.match;
        end
        if (a_move) begin
            r_b.item_kind    <= r_a_kind;
            r_b.ticket_char  <= (r_a_kind == KIND_TICKET) ? r_rd_data : 8'd0;
            r_b.ticket_count <= r_a_cnt;
            r_b.match_found  <= (r_a_kind == KIND_VERDICT) & r_a_match;
            r_b.run_end      <= (r_a_kind == KIND_VERDICT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (issue) begin
                r_idx <= is_ticket ? r_idx + LW'(1) : '0;
            end
            if (issue) begin
                r_a_v <= 1'b1;
            end else if (a_move) begin
                r_a_v <= 1'b0;
            end
            if (a_move) begin
                r_b_v <= 1'b1;
            end else if (i_pop) begin
                r_b_v <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/ble_adv_uuid_ticket_parser_core.sv
// ============================================================================
// BLE advertising UUID/ticket parser core
// Parses advertising payloads as AD structures, checks for a target 128-bit
// UUID and extracts the manufacturer-data ticket, then reports per frame.
// ============================================================================
// Throughput: one payload byte per cycle; results drain at one per cycle while popped.
// Results: the first result of a frame passes the summary queue, the read stage
//   and the output register; a frame yields ticket_length + 1 results.
// Input stalls (full) only while both ticket store banks hold frames not yet drained.
// Reset: synchronous, active low; clears parse state, the summary queue and
//   the UUID registers. The ticket store is not cleared.
module ble_adv_uuid_ticket_parser_core #(
    parameter int TICKET_MAX = bautp_pkg::TICKET_MAX_DEF,
    parameter int ADV_MAX    = bautp_pkg::ADV_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  bautp_pkg::t_in_item  i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output bautp_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);
    import bautp_pkg::*;

    // Address width of one ticket store bank; the bank select sits on top.
    localparam int AW = (TICKET_MAX > 1) ? $clog2(TICKET_MAX) : 1;

    logic        accept;
    logic        wbank, rbank;
    logic        wr_en;
    logic [AW:0] wr_addr;
    logic [7:0]  wr_data;
    logic        desc_push, desc_pop, head_valid;
    t_frame_desc desc, head;

    // A byte transfers whenever the parser's current bank is free.
    assign accept = push && !full;

    // The front end parses each byte in the cycle it transfers and, on the
    // last byte of a frame, pushes the frame summary (ticket length and
    // verdict) into the queue. Ticket bytes go straight into its bank.
    bautp_front #(
        .TICKET_MAX (TICKET_MAX),
        .ADV_MAX    (ADV_MAX),
        .AW         (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_wbank     (wbank),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_desc_push (desc_push),
        .o_desc      (desc)
    );

    // Each queue slot pairs with one ticket store bank, so the next frame
    // can be parsed while the previous one is still draining.
    bautp_frameq u_frameq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (desc_push),
        .i_desc       (desc),
        .i_pop        (desc_pop),
        .o_full       (full),
        .o_wbank      (wbank),
        .o_head_valid (head_valid),
        .o_rbank      (rbank),
        .o_head       (head)
    );

    // The back end reads the stored ticket bytes of the oldest frame, then
    // its verdict, and releases the slot once the verdict is issued.
    bautp_back #(
        .TICKET_MAX (TICKET_MAX),
        .AW         (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_head_valid (head_valid),
        .i_rbank      (rbank),
        .i_head       (head),
        .o_desc_pop   (desc_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_item       (o_out_item)
    );

endmodule
